>>> hw/rtl/csc_pkg.sv
// Shared types and constants for the cosine similarity cost block.
`timescale 1ns / 1ps
package csc_pkg;
    localparam int EL_W      = 16;
    localparam int SQ_W      = 43;
    localparam int XP_W      = 44;
    localparam int PROD_W    = 2 * EL_W;
    localparam int NORM_FRAC = 20;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DEN_W     = 2 * ROOT_W;
    localparam int QUOT_FRAC = 35;
    localparam int COS_W     = 16;
    localparam int COST_W    = 32;

    typedef struct packed {
        logic [SQ_W-1:0]        qsq;
        logic [SQ_W-1:0]        dsq;
        logic signed [XP_W-1:0] xp;
    } sums_t;
endpackage

>>> hw/rtl/cosine_similarity_cost.sv
// Input: one element pair per cycle; the front stalls only when two finished vectors wait.
// Per vector the back runs, where needed, two 32-step square roots in one shared unit,
// a 35-step quotient and a 32-step reciprocal, each one step a cycle.
// Reset: asynchronous, active low; clears the sums, the queue and the output beat.
`timescale 1ns / 1ps
module cosine_similarity_cost (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [csc_pkg::EL_W-1:0]     query_element,
    input  logic signed [csc_pkg::EL_W-1:0]     db_element,
    input  logic                                last_element,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic signed [csc_pkg::COS_W-1:0]    cosine,
    output logic [csc_pkg::COST_W-1:0]          cost,
    output logic                                cost_saturated,
    output logic                                zero_norm,
    output logic                                out_valid,
    input  logic                                out_ready
);
    logic           push, pop, pop_valid;
    logic [1:0]     level;
    csc_pkg::sums_t push_data, pop_data;

    csc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_element (query_element),
        .db_element    (db_element),
        .last_element  (last_element),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .q_level       (level),
        .push          (push),
        .push_data     (push_data)
    );

    csc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .level     (level)
    );

    csc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .sums_valid     (pop_valid),
        .sums           (pop_data),
        .pop            (pop),
        .cosine         (cosine),
        .cost           (cost),
        .cost_saturated (cost_saturated),
        .zero_norm      (zero_norm),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );
endmodule

>>> hw/rtl/csc_front.sv
// Front part: element pair products and the three running sums.
`timescale 1ns / 1ps
module csc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [csc_pkg::EL_W-1:0]     query_element,
    input  logic signed [csc_pkg::EL_W-1:0]     db_element,
    input  logic                                last_element,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          q_level,
    output logic                                push,
    output csc_pkg::sums_t                      push_data
);
    logic signed [csc_pkg::PROD_W-1:0] pq_reg, pd_reg, px_reg;
    logic                              s1_valid_reg, s1_last_reg;
    logic [csc_pkg::SQ_W-1:0]          qsq_reg, dsq_reg, qsq_next, dsq_next;
    logic signed [csc_pkg::XP_W-1:0]   xp_reg, xp_next;
    logic [1:0]                        inflight;
    logic                              accept;

    assign inflight = q_level + {1'b0, s1_valid_reg & s1_last_reg};
    assign in_ready = inflight < 2'd2;
    assign accept   = in_valid & in_ready;

    assign qsq_next = qsq_reg + {{(csc_pkg::SQ_W-csc_pkg::PROD_W){1'b0}}, pq_reg};
    assign dsq_next = dsq_reg + {{(csc_pkg::SQ_W-csc_pkg::PROD_W){1'b0}}, pd_reg};
    assign xp_next  = xp_reg + {{(csc_pkg::XP_W-csc_pkg::PROD_W){px_reg[csc_pkg::PROD_W-1]}},
                                px_reg};

    assign push          = s1_valid_reg & s1_last_reg;
    assign push_data.qsq = qsq_next;
    assign push_data.dsq = dsq_next;
    assign push_data.xp  = xp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            qsq_reg      <= '0;
            dsq_reg      <= '0;
            xp_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
                s1_last_reg <= last_element;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    qsq_reg <= '0;
                    dsq_reg <= '0;
                    xp_reg  <= '0;
                end
                else
                begin
                    qsq_reg <= qsq_next;
                    dsq_reg <= dsq_next;
                    xp_reg  <= xp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pq_reg <= query_element * query_element;
            pd_reg <= db_element * db_element;
            px_reg <= query_element * db_element;
        end
    end
endmodule

>>> hw/rtl/csc_queue.sv
// Two-entry queue of finished sums between the front and back parts.
`timescale 1ns / 1ps
module csc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csc_pkg::sums_t  push_data,
    input  logic            pop,
    output logic            pop_valid,
    output csc_pkg::sums_t  pop_data,
    output logic [1:0]      level
);
    csc_pkg::sums_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_pop;

    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign do_pop    = pop & pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end
endmodule

>>> hw/rtl/csc_back.sv
// Back part: norms, scaled quotient, cosine and cost, with the output register.
`timescale 1ns / 1ps
module csc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sums_valid,
    input  csc_pkg::sums_t                      sums,
    output logic                                pop,
    output logic signed [csc_pkg::COS_W-1:0]    cosine,
    output logic [csc_pkg::COST_W-1:0]          cost,
    output logic                                cost_saturated,
    output logic                                zero_norm,
    output logic                                out_valid,
    input  logic                                out_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DVI  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_CSN  = 3'd5;
    localparam logic [2:0] ST_COST = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam int Q_W   = 36;
    localparam logic [csc_pkg::RAD_W-1:0] ONE_TOP = {2'b01, {(csc_pkg::RAD_W-2){1'b0}}};
    localparam logic [Q_W-1:0] M_CAP = 36'd65536;

    logic [2:0]                      state_reg, state_next;
    logic [5:0]                      cnt_reg, cnt_next;
    logic                            sel_reg, sel_next;
    logic [csc_pkg::SQ_W-1:0]        dsq_reg, dsq_next;
    logic [csc_pkg::XP_W-1:0]        mag_reg, mag_next;
    logic                            neg_reg, neg_next;
    logic [csc_pkg::RAD_W-1:0]       op_reg, op_next, res_reg, res_next, one_reg, one_next;
    logic [csc_pkg::ROOT_W-1:0]      nq_reg, nq_next, nd_reg, nd_next;
    logic [csc_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [csc_pkg::DEN_W:0]         r_reg, r_next;
    logic [Q_W-1:0]                  q_reg, q_next;
    logic [csc_pkg::COS_W-1:0]       cos_reg, cos_next;
    logic [csc_pkg::COS_W-1:0]       cr_reg, cr_next;
    logic [csc_pkg::COST_W-1:0]      cq_reg, cq_next;
    logic                            zn_reg, zn_next, sat_reg, sat_next;
    logic signed [csc_pkg::COS_W-1:0] o_cos_reg, o_cos_next;
    logic [csc_pkg::COST_W-1:0]      o_cost_reg, o_cost_next;
    logic                            o_sat_reg, o_sat_next, o_zn_reg, o_zn_next;
    logic                            o_valid_reg, o_valid_next;

    logic [csc_pkg::RAD_W-1:0]       trial;
    logic [csc_pkg::RAD_W-1:0]       step_op, step_res;
    logic [csc_pkg::DEN_W:0]         r2;
    logic [16:0]                     msat, mneg;
    logic [csc_pkg::COS_W:0]         cr2;
    logic [csc_pkg::COS_W:0]         divisor;

    assign trial    = res_reg + one_reg;
    assign step_op  = (op_reg >= trial) ? op_reg - trial : op_reg;
    assign step_res = (op_reg >= trial) ? (res_reg >> 1) + one_reg : res_reg >> 1;
    assign r2       = {r_reg[csc_pkg::DEN_W-1:0], 1'b0};
    assign msat     = (q_reg >= M_CAP) ? 17'd65536 : q_reg[16:0];
    assign mneg     = (msat > 17'd32768) ? 17'd32768 : msat;
    assign cr2      = {cr_reg, (cnt_reg == 6'd31)};
    assign divisor  = {1'b0, cos_reg};

    assign pop            = (state_reg == ST_IDLE) & sums_valid;
    assign cosine         = o_cos_reg;
    assign cost           = o_cost_reg;
    assign cost_saturated = o_sat_reg;
    assign zero_norm      = o_zn_reg;
    assign out_valid      = o_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        dsq_next     = dsq_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        one_next     = one_reg;
        nq_next      = nq_reg;
        nd_next      = nd_reg;
        den_next     = den_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        cos_next     = cos_reg;
        cr_next      = cr_reg;
        cq_next      = cq_reg;
        zn_next      = zn_reg;
        sat_next     = sat_reg;
        o_cos_next   = o_cos_reg;
        o_cost_next  = o_cost_reg;
        o_sat_next   = o_sat_reg;
        o_zn_next    = o_zn_reg;
        o_valid_next = o_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (sums_valid)
                begin
                    dsq_next = sums.dsq;
                    neg_next = sums.xp[csc_pkg::XP_W-1];
                    mag_next = sums.xp[csc_pkg::XP_W-1] ? (~sums.xp + 1'b1) : sums.xp;
                    cos_next = '0;
                    cq_next  = '1;
                    sat_next = 1'b1;
                    zn_next  = 1'b0;
                    if (sums.qsq == '0 || sums.dsq == '0)
                    begin
                        zn_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op_next    = {1'b0, sums.qsq, {csc_pkg::NORM_FRAC{1'b0}}};
                        res_next   = '0;
                        one_next   = ONE_TOP;
                        sel_next   = 1'b0;
                        cnt_next   = 6'd31;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                op_next  = step_op;
                res_next = step_res;
                one_next = one_reg >> 2;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    if (!sel_reg)
                    begin
                        nq_next  = step_res[csc_pkg::ROOT_W-1:0];
                        op_next  = {1'b0, dsq_reg, {csc_pkg::NORM_FRAC{1'b0}}};
                        res_next = '0;
                        one_next = ONE_TOP;
                        sel_next = 1'b1;
                        cnt_next = 6'd31;
                    end
                    else
                    begin
                        nd_next    = step_res[csc_pkg::ROOT_W-1:0];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                den_next   = nq_reg * nd_reg;
                state_next = ST_DVI;
            end
            ST_DVI:
            begin
                if ({{(csc_pkg::DEN_W-csc_pkg::XP_W){1'b0}}, mag_reg} >= den_reg)
                begin
                    q_next     = M_CAP;
                    state_next = ST_CSN;
                end
                else
                begin
                    r_next     = {{(csc_pkg::DEN_W+1-csc_pkg::XP_W){1'b0}}, mag_reg};
                    q_next     = '0;
                    cnt_next   = 6'(csc_pkg::QUOT_FRAC - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (r2 >= {1'b0, den_reg})
                begin
                    r_next = r2 - {1'b0, den_reg};
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r2;
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = ST_CSN;
            end
            ST_CSN:
            begin
                if (neg_reg)
                begin
                    cos_next   = 16'(~mneg + 17'd1);
                    state_next = ST_DONE;
                end
                else if (msat == 17'd0)
                begin
                    cos_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cos_next   = (msat > 17'd32767) ? 16'd32767 : msat[15:0];
                    cr_next    = '0;
                    cq_next    = '0;
                    cnt_next   = 6'd31;
                    state_next = ST_COST;
                end
            end
            ST_COST:
            begin
                if (cr2 >= divisor)
                begin
                    cr_next = 16'(cr2 - divisor);
                    cq_next = {cq_reg[csc_pkg::COST_W-2:0], 1'b1};
                end
                else
                begin
                    cr_next = cr2[csc_pkg::COS_W-1:0];
                    cq_next = {cq_reg[csc_pkg::COST_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!o_valid_reg || out_ready)
                begin
                    o_cos_next   = cos_reg;
                    o_cost_next  = cq_reg;
                    o_sat_next   = sat_reg;
                    o_zn_next    = zn_reg;
                    o_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        sel_reg    <= sel_next;
        dsq_reg    <= dsq_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        op_reg     <= op_next;
        res_reg    <= res_next;
        one_reg    <= one_next;
        nq_reg     <= nq_next;
        nd_reg     <= nd_next;
        den_reg    <= den_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        cos_reg    <= cos_next;
        cr_reg     <= cr_next;
        cq_reg     <= cq_next;
        zn_reg     <= zn_next;
        sat_reg    <= sat_next;
        o_cos_reg  <= o_cos_next;
        o_cost_reg <= o_cost_next;
        o_sat_reg  <= o_sat_next;
        o_zn_reg   <= o_zn_next;
    end
endmodule

>>> hw/rtl/csc_checker.sv
// Port-level checks for the cosine similarity cost block and their binding.
`timescale 1ns / 1ps
module csc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [csc_pkg::COS_W-1:0] cosine,
    input logic [csc_pkg::COST_W-1:0]       cost,
    input logic                             cost_saturated,
    input logic                             zero_norm
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cost) && $stable(cosine))
        else $error("result beat changed while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> cosine == 16'sd0 && cost_saturated)
        else $error("zero norm result not cleared");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cost_saturated == (cosine <= 16'sd0))
        else $error("saturation flag disagrees with cosine sign");

    a_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cost_saturated |-> cost == 32'hFFFF_FFFF)
        else $error("saturated cost not at maximum");
endmodule

bind cosine_similarity_cost csc_checker u_csc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cosine         (cosine),
    .cost           (cost),
    .cost_saturated (cost_saturated),
    .zero_norm      (zero_norm)
);

>>> verif/cosine_similarity_cost_tb.sv
// Testbench for the cosine similarity cost block: streamed vectors against a local predictor.
`timescale 1ns / 1ps
module cosine_similarity_cost_tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    localparam int MODE_RANDOM   = 0;
    localparam int MODE_SAME     = 1;
    localparam int MODE_OPPOSITE = 2;
    localparam int MODE_NEAR     = 3;
    localparam int MODE_SPARSE   = 4;

    typedef struct packed {
        logic signed [csc_pkg::COS_W-1:0] cos_val;
        logic [csc_pkg::COST_W-1:0]       cost_val;
        logic                             sat;
        logic                             zn;
    } match_t;

    logic                             clk;
    logic                             rst_n;
    logic signed [csc_pkg::EL_W-1:0]  query_element;
    logic signed [csc_pkg::EL_W-1:0]  db_element;
    logic                             last_element;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [csc_pkg::COS_W-1:0] cosine;
    logic [csc_pkg::COST_W-1:0]       cost;
    logic                             cost_saturated;
    logic                             zero_norm;
    logic                             out_valid;
    logic                             out_ready;

    logic [csc_pkg::SQ_W-1:0]         q_sq_acc;
    logic [csc_pkg::SQ_W-1:0]         d_sq_acc;
    logic [csc_pkg::XP_W-1:0]         dot_acc;
    match_t                           expected_matches[$];
    int                               fail_count;
    int                               idle_count;
    bit                               calm;
    int                               hold_off;

    cosine_similarity_cost u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .query_element  (query_element),
        .db_element     (db_element),
        .last_element   (last_element),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cosine         (cosine),
        .cost           (cost),
        .cost_saturated (cost_saturated),
        .zero_norm      (zero_norm),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] op;
        logic [63:0] res;
        logic [63:0] bitv;
        op = x;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > op)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (op >= res + bitv)
            begin
                op = op - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] cos_magnitude(input logic [63:0] mag,
                                                  input logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, mag} << csc_pkg::QUOT_FRAC) / {64'd0, den};
        return (q > 128'd65536) ? 64'd65536 : q[63:0];
    endfunction

    // Accumulate one pair; on the last one, queue the expected match and clear.
    task automatic predict_pair(input logic signed [csc_pkg::EL_W-1:0] qe,
                                input logic signed [csc_pkg::EL_W-1:0] de,
                                input logic last);
        logic signed [csc_pkg::PROD_W-1:0] qq;
        logic signed [csc_pkg::PROD_W-1:0] dd;
        logic signed [csc_pkg::PROD_W-1:0] qd;
        logic [63:0] nq;
        logic [63:0] nd;
        logic [63:0] mag;
        logic [63:0] m;
        logic neg;
        match_t r;
        qq = qe * qe;
        dd = de * de;
        qd = qe * de;
        q_sq_acc = q_sq_acc + csc_pkg::SQ_W'($unsigned(qq));
        d_sq_acc = d_sq_acc + csc_pkg::SQ_W'($unsigned(dd));
        dot_acc = dot_acc + csc_pkg::XP_W'(qd);
        if (!last)
            return;
        r.cos_val = '0;
        r.cost_val = '1;
        r.sat = 1'b1;
        r.zn = 1'b0;
        if (q_sq_acc == 0 || d_sq_acc == 0)
            r.zn = 1'b1;
        else
        begin
            nq = int_sqrt({21'd0, q_sq_acc} << csc_pkg::NORM_FRAC);
            nd = int_sqrt({21'd0, d_sq_acc} << csc_pkg::NORM_FRAC);
            neg = dot_acc[csc_pkg::XP_W-1];
            mag = neg ? 64'((45'd1 << csc_pkg::XP_W) - {1'b0, dot_acc}) : {20'd0, dot_acc};
            m = cos_magnitude(mag, nq * nd);
            if (neg)
                r.cos_val = -csc_pkg::COS_W'((m > 32768) ? 64'd32768 : m);
            else
                r.cos_val = csc_pkg::COS_W'((m > 32767) ? 64'd32767 : m);
            if (r.cos_val > 0)
            begin
                r.cost_val = csc_pkg::COST_W'((64'd1 << 31) / 64'(r.cos_val));
                r.sat = 1'b0;
            end
        end
        expected_matches.insert(expected_matches.size(), r);
        q_sq_acc = '0;
        d_sq_acc = '0;
        dot_acc = '0;
    endtask

    task automatic send_pair(input logic signed [csc_pkg::EL_W-1:0] qe,
                             input logic signed [csc_pkg::EL_W-1:0] de,
                             input logic last);
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        query_element <= qe;
        db_element <= de;
        last_element <= last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pair(qe, de, last);
        @(negedge clk);
    endtask

    task automatic send_vector(input int len, input int mode);
        logic signed [csc_pkg::EL_W-1:0] qe;
        logic signed [csc_pkg::EL_W-1:0] de;
        for (int i = 0; i < len; i++)
        begin
            qe = csc_pkg::EL_W'($urandom);
            de = csc_pkg::EL_W'($urandom);
            case (mode)
                MODE_SAME: de = qe;
                MODE_OPPOSITE: de = -qe;
                MODE_NEAR:
                    de = csc_pkg::EL_W'(qe + $signed(csc_pkg::EL_W'($urandom_range(64))) - 32);
                MODE_SPARSE: de = (i % 2) ? 16'sd0 : de;
                default: ;
            endcase
            send_pair(qe, de, i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(-16'sh8000, -16'sh8000, 1'b1);
        send_pair(-16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh7fff, -16'sh8000, 1'b1);
        send_pair(16'sd0, 16'sd1234, 1'b1);
        send_pair(-16'sd77, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b1);
        send_pair(16'sh5555, 16'sh2aaa, 1'b0);
        send_pair(-16'sh5556, 16'sh5555, 1'b1);
        send_pair(16'sd100, 16'sd99, 1'b0);
        send_pair(16'sd100, 16'sd101, 1'b1);
    endtask

    task automatic test_random_vectors();
        int sent;
        sent = 0;
        while (sent < 520)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
            send_vector(len, $urandom_range(MODE_SPARSE));
            sent += len;
        end
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        for (int k = 0; k < 10; k++)
            send_vector($urandom_range(3, 1), $urandom_range(MODE_SPARSE));
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off = 1500;
        for (int k = 0; k < 12; k++)
            send_vector(1, $urandom_range(MODE_SPARSE));
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_matches.size() == 0)
            begin
                $display("%0t: unexpected match beat cosine=%0d cost=%h", $time, cosine, cost);
                fail_count++;
            end
            else
            begin
                match_t e;
                e = expected_matches.pop_front();
                if (cosine !== e.cos_val)
                begin
                    $display("%0t: cosine expected %0d actual %0d", $time, e.cos_val, cosine);
                    fail_count++;
                end
                if (cost !== e.cost_val)
                begin
                    $display("%0t: cost expected %h actual %h", $time, e.cost_val, cost);
                    fail_count++;
                end
                if (cost_saturated !== e.sat)
                begin
                    $display("%0t: cost_saturated expected %b actual %b", $time, e.sat,
                             cost_saturated);
                    fail_count++;
                end
                if (zero_norm !== e.zn)
                begin
                    $display("%0t: zero_norm expected %b actual %b", $time, e.zn, zero_norm);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("cosine_similarity_cost test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        query_element = '0;
        db_element = '0;
        last_element = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        q_sq_acc = '0;
        d_sq_acc = '0;
        dot_acc = '0;
        fail_count = 0;
        idle_count = 0;
        calm = 1'b0;
        hold_off = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random_vectors();
        test_no_idle();
        in_valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cosine_similarity_cost test passed");
        else
            $display("cosine_similarity_cost test failed");
        $finish;
    end
endmodule
